@@ hw/rtl/mmmt_pkg.sv @@
// Shared types and constants for the multiset min/max/mean tracker.
`timescale 1ns / 1ps
`default_nettype none
package mmmt_pkg;

  localparam int VALUE_W           = 32;
  localparam int MEAN_W            = 48;
  localparam int DEF_STORE_DEPTH   = 64;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOVE,
    S_RESCAN,
    S_MEAN,
    S_DIV,
    S_RESULT
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/multiset_min_max_mean_tracker.sv @@
// Top level: bounded multiset with running count, sum, minimum, maximum and mean.
// Insert runs the mean step (a serial divide unless the set is empty) before out_tvalid;
//   remove adds a search of the store and, on a hit, a move and, if min or max went, a bound rescan.
// Throughput: one transaction at a time; in_tready returns with out_tvalid unless the
//   prior result is still stalled. The serial divider and store walks set how long each one takes.
// Reset: synchronous active-low rst_n clears count, sum, min, max and control only.
`timescale 1ns / 1ps
`default_nettype none
module multiset_min_max_mean_tracker #(
  parameter int STORE_DEPTH   = mmmt_pkg::DEF_STORE_DEPTH,
  parameter int FRACTION_BITS = mmmt_pkg::DEF_FRACTION_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] value
  input  wire logic [0:0]   in_tuser,   // [0] cmd
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // [31:0] min_value, [63:32] max_value,
                                        // [111:64] mean_value
  output logic [2:0]        out_tuser   // [0] is_empty, [2:1] status
);

  localparam int VW    = mmmt_pkg::VALUE_W;
  localparam int MW    = mmmt_pkg::MEAN_W;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W = VW + IDX_W;           // holds STORE_DEPTH * full-scale value
  localparam int NUM_W = SUM_W + FRACTION_BITS; // |sum| scaled by 2^FRACTION_BITS

  // ---------------------------------------------------------------- state
  mmmt_pkg::state_t          state_r, state_nxt;
  mmmt_pkg::status_t         status_r, status_nxt;
  logic signed [VW-1:0]      value_r, value_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [VW-1:0]      min_r, min_nxt;
  logic signed [VW-1:0]      max_r, max_nxt;
  logic signed [VW-1:0]      lo_r, lo_nxt;
  logic signed [VW-1:0]      hi_r, hi_nxt;
  logic                      want_min_r, want_min_nxt;
  logic                      want_max_r, want_max_nxt;
  logic [CNT_W-1:0]          ptr_r, ptr_nxt;      // next store address to read
  logic [IDX_W-1:0]          chk_r, chk_nxt;      // address of the word in rd_data_r
  logic                      chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]          hit_r, hit_nxt;
  logic [MW-1:0]             mean_r, mean_nxt;

  // output register
  logic                      out_vld_r, out_vld_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [VW-1:0]             out_min_r, out_min_nxt;
  logic [VW-1:0]             out_max_r, out_max_nxt;
  logic [MW-1:0]             out_mean_r, out_mean_nxt;

  // ---------------------------------------------------------------- store
  logic signed [VW-1:0]      store_mem [STORE_DEPTH];
  logic signed [VW-1:0]      rd_data_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic signed [VW-1:0]      mem_wdata;
  logic [IDX_W-1:0]          mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[mem_raddr];
  end

  // ---------------------------------------------------------------- helpers
  logic                      in_fire;
  logic signed [VW-1:0]      in_val;
  logic [CNT_W-1:0]          last_idx;
  logic                      hit;
  logic                      last_chk;
  logic                      sum_neg;
  logic [SUM_W-1:0]          sum_mag;
  logic [NUM_W-1:0]          div_numer;
  logic                      div_start;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;
  logic [MW-1:0]             quot_mw;
  logic signed [VW-1:0]      scan_lo;
  logic signed [VW-1:0]      scan_hi;
  logic                      out_free;

  assign in_tready = (state_r == mmmt_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_val    = signed'(in_tdata);
  assign out_free  = !out_vld_r || out_tready;

  assign last_idx  = count_r - CNT_W'(1);
  assign hit       = chk_vld_r && (rd_data_r == value_r);
  assign last_chk  = chk_vld_r && (CNT_W'(chk_r) == last_idx);

  // mean = sign * floor(|sum| * 2^F / count): one division of the scaled magnitude
  assign sum_neg   = sum_r[SUM_W-1];
  assign sum_mag   = sum_neg ? (SUM_W'(0) - unsigned'(sum_r)) : unsigned'(sum_r);
  assign div_numer = NUM_W'(sum_mag) << FRACTION_BITS;
  assign quot_mw   = MW'(div_quot);

  // running bounds of a rescan, the first word seeds them
  always_comb begin
    if (chk_r == '0) begin
      scan_lo = rd_data_r;
      scan_hi = rd_data_r;
    end else begin
      scan_lo = (rd_data_r < lo_r) ? rd_data_r : lo_r;
      scan_hi = (rd_data_r > hi_r) ? rd_data_r : hi_r;
    end
  end

  mmmt_serial_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (count_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmmt_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == mmmt_pkg::CMD_INSERT || count_r == '0) begin
            state_nxt = mmmt_pkg::S_MEAN;
          end else begin
            state_nxt = mmmt_pkg::S_SEARCH;
          end
        end
      end
      mmmt_pkg::S_SEARCH: begin
        if (hit) begin
          state_nxt = mmmt_pkg::S_MOVE;
        end else if (last_chk) begin
          state_nxt = mmmt_pkg::S_MEAN;
        end
      end
      mmmt_pkg::S_MOVE: begin
        if (count_r != CNT_W'(1) && (value_r == min_r || value_r == max_r)) begin
          state_nxt = mmmt_pkg::S_RESCAN;
        end else begin
          state_nxt = mmmt_pkg::S_MEAN;
        end
      end
      mmmt_pkg::S_RESCAN: begin
        if (last_chk) begin
          state_nxt = mmmt_pkg::S_MEAN;
        end
      end
      mmmt_pkg::S_MEAN: begin
        if (count_r == '0) begin
          state_nxt = mmmt_pkg::S_RESULT;
        end else begin
          state_nxt = mmmt_pkg::S_DIV;
        end
      end
      mmmt_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = mmmt_pkg::S_RESULT;
        end
      end
      mmmt_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = mmmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mmmt_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    status_nxt     = status_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    want_min_nxt   = want_min_r;
    want_max_nxt   = want_max_r;
    ptr_nxt        = ptr_r;
    chk_nxt        = chk_r;
    chk_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    mean_nxt       = mean_r;
    mem_we         = 1'b0;
    mem_waddr      = hit_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = ptr_r[IDX_W-1:0];
    div_start      = 1'b0;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_mean_nxt   = out_mean_r;

    case (state_r)
      mmmt_pkg::S_IDLE: begin
        if (in_fire) begin
          value_nxt  = in_val;
          status_nxt = mmmt_pkg::ST_DONE;
          ptr_nxt    = '0;
          if (in_tuser[0] == mmmt_pkg::CMD_INSERT) begin
            if (count_r == CNT_W'(STORE_DEPTH)) begin
              status_nxt = mmmt_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[IDX_W-1:0];
              mem_wdata = in_val;
              count_nxt = count_r + CNT_W'(1);
              sum_nxt   = sum_r + SUM_W'(in_val);
              if (count_r == '0) begin
                min_nxt = in_val;
                max_nxt = in_val;
              end else begin
                if (in_val > max_r) max_nxt = in_val;
                if (in_val < min_r) min_nxt = in_val;
              end
            end
          end else if (count_r == '0) begin
            status_nxt = mmmt_pkg::ST_NO_MATCH;
          end
        end
      end
      mmmt_pkg::S_SEARCH: begin
        if (hit) begin
          // fetch the last entry to fill the hole
          hit_nxt   = chk_r;
          mem_raddr = last_idx[IDX_W-1:0];
        end else if (last_chk) begin
          status_nxt = mmmt_pkg::ST_NO_MATCH;
        end else if (ptr_r < count_r) begin
          chk_vld_nxt = 1'b1;
          chk_nxt     = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + CNT_W'(1);
        end
      end
      mmmt_pkg::S_MOVE: begin
        mem_we       = 1'b1;
        count_nxt    = last_idx;
        ptr_nxt      = '0;
        want_min_nxt = (value_r == min_r);
        want_max_nxt = (value_r == max_r);
        if (count_r == CNT_W'(1)) begin
          sum_nxt = '0;
          min_nxt = '0;
          max_nxt = '0;
        end else begin
          sum_nxt = sum_r - SUM_W'(value_r);
        end
      end
      mmmt_pkg::S_RESCAN: begin
        if (ptr_r < count_r) begin
          chk_vld_nxt = 1'b1;
          chk_nxt     = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          lo_nxt = scan_lo;
          hi_nxt = scan_hi;
          if (last_chk) begin
            if (want_min_r) min_nxt = scan_lo;
            if (want_max_r) max_nxt = scan_hi;
          end
        end
      end
      mmmt_pkg::S_MEAN: begin
        if (count_r == '0) begin
          mean_nxt = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      mmmt_pkg::S_DIV: begin
        if (div_done) begin
          mean_nxt = sum_neg ? (MW'(0) - quot_mw) : quot_mw;
        end
      end
      mmmt_pkg::S_RESULT: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_empty_nxt  = (count_r == '0);
          out_status_nxt = status_r;
          out_min_nxt    = (count_r == '0) ? '0 : min_r;
          out_max_nxt    = (count_r == '0) ? '0 : max_r;
          out_mean_nxt   = mean_r;
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mmmt_pkg::S_IDLE;
      count_r   <= '0;
      sum_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    status_r     <= status_nxt;
    value_r      <= value_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    want_min_r   <= want_min_nxt;
    want_max_r   <= want_max_nxt;
    ptr_r        <= ptr_nxt;
    chk_r        <= chk_nxt;
    hit_r        <= hit_nxt;
    mean_r       <= mean_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_mean_r   <= out_mean_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_mean_r, out_max_r, out_min_r};
  assign out_tuser  = {out_status_r, out_empty_r};

endmodule
`default_nettype wire

@@ hw/rtl/mmmt_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, used by the mean computation.
`timescale 1ns / 1ps
`default_nettype none
module mmmt_serial_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // remainder stays below the divisor, so DEN_W bits hold it between steps
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = denom;
      quo_nxt  = numer;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire
